FILE: rtl/top_k_frequent_keys_assert.svh
// assertion helpers used by top_k_frequent_keys.sv
`ifndef TOP_K_FREQUENT_KEYS_ASSERT_SVH
`define TOP_K_FREQUENT_KEYS_ASSERT_SVH

// same-cycle implication
`define TKF_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tkf_pkg.sv
`default_nettype none
package tkf_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned K_W         = 7;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned MAX_KEYS_DF = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [K_W-1:0]   RESULT_CAP = 7'd64;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_FEW = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVF     = 2'd2;

  typedef enum logic [2:0] {
    S_COUNT,
    S_DECIDE,
    S_START,
    S_SCAN,
    S_EMIT
  } state_e;

  // best candidate travelling down the cell row
  typedef struct packed {
    logic             tok;
    logic             found;
    logic [CNT_W-1:0] cnt;
    logic [KEY_W-1:0] key;
  } chain_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic inc_en;
    logic new_en;
    logic pick_en;
    logic clr_pick;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/tkf_in_if.sv
`default_nettype none
interface tkf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] key_value;
  logic               batch_last;

  modport source (output valid, key_value, batch_last, input ready);
  modport sink   (input valid, key_value, batch_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/tkf_out_if.sv
`default_nettype none
interface tkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_key;
  logic        [15:0] key_count;
  logic        [1:0]  status;
  logic               result_last;

  modport source (output valid, top_key, key_count, status, result_last, input ready);
  modport sink   (input valid, top_key, key_count, status, result_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/tkf_cfg_if.sv
`default_nettype none
interface tkf_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] k_wanted;

  modport source (output valid, k_wanted, input ready);
  modport sink   (input valid, k_wanted, output ready);
endinterface
`default_nettype wire

FILE: rtl/tkf_cell.sv
`default_nettype none
module tkf_cell
  import tkf_pkg::*;
#(
  parameter int unsigned MAX_KEYS = MAX_KEYS_DF,
  parameter int unsigned IDX      = 0,
  localparam int unsigned UW      = $clog2(MAX_KEYS + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire  [KEY_W-1:0] key_i,
  input  wire  [UW-1:0]    used_i,
  input  wire  cell_ctl_t  ctl_i,
  input  wire  chain_t     chain_i,
  output chain_t           chain_o,
  output logic             hit_o
);

  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] cnt_q;
  logic             picked_q;
  logic             tok_q;
  logic             found_q;
  logic [CNT_W-1:0] bcnt_q;
  logic [KEY_W-1:0] bkey_q;
  logic             occ;
  logic             slot;
  logic             elig;

  assign occ   = UW'(IDX) < used_i;
  assign slot  = UW'(IDX) == used_i;
  assign hit_o = occ && (key_q == key_i);
  assign elig  = occ && !picked_q && (!chain_i.found || cnt_q > chain_i.cnt);

  always_ff @(posedge clk_i) begin
    if (ctl_i.new_en && slot) begin
      key_q <= key_i;
      cnt_q <= CNT_W'(1);
    end else if (ctl_i.inc_en && hit_o && cnt_q != COUNT_MAX) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (elig) begin
      found_q <= 1'b1;
      bcnt_q  <= cnt_q;
      bkey_q  <= key_q;
    end else begin
      found_q <= chain_i.found;
      bcnt_q  <= chain_i.cnt;
      bkey_q  <= chain_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      picked_q <= 1'b0;
      tok_q    <= 1'b0;
    end else begin
      tok_q <= chain_i.tok;
      if (ctl_i.clr_pick) begin
        picked_q <= 1'b0;
      end else if (ctl_i.pick_en && hit_o) begin
        picked_q <= 1'b1;
      end
    end
  end

  assign chain_o = '{tok: tok_q, found: found_q, cnt: bcnt_q, key: bkey_q};

endmodule
`default_nettype wire

FILE: rtl/top_k_frequent_keys.sv
// counting, only in S_COUNT: one key per cycle, the count is updated when accepted
// after the last key: a decision state, then for each reported key a start, a scan
// in which the best candidate walks the row of MAX_KEYS cells, and an emit state
// a status-only result (overflow or too few keys) is sent from the decision state
// reset empties the table, clears overflow and sets k_wanted to 1
`default_nettype none
module top_k_frequent_keys
  import tkf_pkg::*;
#(
  parameter int unsigned MAX_KEYS = MAX_KEYS_DF
) (
  input wire         clk_i,
  input wire         rst_ni,
  tkf_in_if.sink     in_i,
  tkf_out_if.source  out_o,
  tkf_cfg_if.sink    cfg_i
);

  `include "top_k_frequent_keys_assert.svh"

  localparam int unsigned UW = $clog2(MAX_KEYS + 1);
  localparam int unsigned CW = (UW > K_W) ? UW : K_W;

  state_e            state_q, state_d;
  logic [UW-1:0]     used_q, used_d;
  logic              ovf_q, ovf_d;
  logic [K_W-1:0]    k_q;
  logic [K_W-1:0]    n_q, n_d;
  logic [KEY_W-1:0]  res_key_q, res_key_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [KEY_W-1:0]  out_key_q, out_key_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;
  logic              out_last_q, out_last_d;

  logic [K_W-1:0]    k_eff;
  logic              out_free;
  logic              accept;
  logic              any_hit;
  logic              start_tok;
  logic [KEY_W-1:0]  key_bus;
  logic [MAX_KEYS-1:0] hit_vec;
  cell_ctl_t         ctl;
  chain_t            chain [MAX_KEYS+1];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_W'(1);
    end else if (cfg_i.valid) begin
      k_q <= cfg_i.k_wanted;
    end
  end

  assign k_eff = (k_q == '0) ? K_W'(1) : ((k_q > RESULT_CAP) ? RESULT_CAP : k_q);

  assign in_i.ready = (state_q == S_COUNT);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign any_hit    = |hit_vec;
  assign key_bus    = (state_q == S_COUNT) ? in_i.key_value : res_key_q;

  assign chain[0] = '{tok: start_tok, found: 1'b0, cnt: '0, key: '0};

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    tkf_cell #(
      .MAX_KEYS (MAX_KEYS),
      .IDX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_bus),
      .used_i  (used_q),
      .ctl_i   (ctl),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .hit_o   (hit_vec[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    res_key_d   = res_key_q;
    res_cnt_d   = res_cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_key_d   = out_key_q;
    out_cnt_d   = out_cnt_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    start_tok   = 1'b0;
    ctl         = '0;

    unique case (state_q)
      S_COUNT: begin
        if (accept) begin
          ctl.inc_en = 1'b1;
          if (!any_hit) begin
            if (used_q < UW'(MAX_KEYS)) begin
              ctl.new_en = 1'b1;
              used_d     = used_q + UW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (in_i.batch_last) begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        ctl.clr_pick = 1'b1;
        n_d          = '0;
        if (ovf_q || CW'(used_q) < CW'(k_eff)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_key_d   = '0;
            out_cnt_d   = '0;
            out_stat_d  = ovf_q ? ST_OVF : ST_TOO_FEW;
            out_last_d  = 1'b1;
            used_d      = '0;
            ovf_d       = 1'b0;
            state_d     = S_COUNT;
          end
        end else begin
          state_d = S_START;
        end
      end
      S_START: begin
        start_tok = 1'b1;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (chain[MAX_KEYS].tok) begin
          res_key_d = chain[MAX_KEYS].key;
          res_cnt_d = chain[MAX_KEYS].cnt;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.pick_en = 1'b1;
          out_valid_d = 1'b1;
          out_key_d   = res_key_q;
          out_cnt_d   = res_cnt_q;
          out_stat_d  = ST_OK;
          out_last_d  = (n_q + K_W'(1) == k_eff);
          n_d         = n_q + K_W'(1);
          if (n_q + K_W'(1) == k_eff) begin
            used_d  = '0;
            ovf_d   = 1'b0;
            state_d = S_COUNT;
          end else begin
            state_d = S_START;
          end
        end
      end
      default: state_d = S_COUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_COUNT;
      used_q      <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_key_q  <= res_key_d;
    res_cnt_q  <= res_cnt_d;
    out_key_q  <= out_key_d;
    out_cnt_q  <= out_cnt_d;
    out_stat_q <= out_stat_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.top_key     = out_key_q;
  assign out_o.key_count   = out_cnt_q;
  assign out_o.status      = out_stat_q;
  assign out_o.result_last = out_last_q;

  `TKF_ASSERT_HOLDS(a_used_bound, 1'b1, used_q <= UW'(MAX_KEYS), "table fill beyond size")
  `TKF_ASSERT_HOLDS(a_one_hit, accept, $onehot0(hit_vec), "key stored in two cells")
  `TKF_ASSERT_HOLDS(a_tok_scan, chain[MAX_KEYS].tok, state_q == S_SCAN,
                    "candidate left the row outside a scan")
  `TKF_ASSERT_NEXT(a_start_scan, state_q == S_START, state_q == S_SCAN,
                   "scan did not follow start")
  `TKF_ASSERT_HOLDS(a_ok_nonzero, out_valid_q && out_stat_q == ST_OK, out_cnt_q != '0,
                    "reported key with zero count")

endmodule
`default_nettype wire
